// ----- rtl/c2p_pkg.sv -----
package c2p_pkg;

    // Field formats.
    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    // Derived widths.
    localparam int SQ_W   = 2 * DATA_WIDTH;      // px^2 + py^2
    localparam int ROOT_W = DATA_WIDTH;          // range
    localparam int DOT_W  = 2 * DATA_WIDTH + 1;  // px*vx + py*vy, signed
    localparam int RATE_W = 33;
    localparam int BEAR_W = 19;
    localparam int CW     = DATA_WIDTH + 4;      // CORDIC x and y
    localparam int ZW     = 36;                  // CORDIC angle, Q30

    // Angle constants in Q30 and the rounding to the output format.
    localparam logic signed [ZW-1:0] PI_Q30   = 36'sd3373259426;
    localparam int                   RND_SH   = 30 - FRAC_BITS;
    localparam logic signed [ZW-1:0] RND_HALF = ZW'(64'sd1 <<< (RND_SH - 1));
    localparam logic signed [ZW-1:0] BEAR_LIM = ZW'((64'sd3373259426 +
                                                 (64'sd1 <<< (RND_SH - 1))) >>> RND_SH);

    // Range rate saturation level.
    localparam logic [RATE_W-1:0] RATE_LIMIT = 33'd3037000500;

    // Pipeline depths: bearing is delayed to meet the range rate path.
    localparam int MAIN_DEPTH = 2 + ROOT_W + 1 + ROOT_W;
    localparam int BEAR_DEPTH = CORDIC_STEPS + 2;
    localparam int BEAR_DELAY = MAIN_DEPTH - BEAR_DEPTH;

    // Flags that ride along with the divider.
    typedef struct packed {
        logic sat;
        logic zero;
        logic neg;
    } rate_flags_t;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
        logic signed [ZW-1:0] one;
        one = 1;
        case (i)
            0:       return 36'sd843314857;
            1:       return 36'sd497837829;
            2:       return 36'sd263043837;
            3:       return 36'sd133525159;
            4:       return 36'sd67021687;
            5:       return 36'sd33543516;
            6:       return 36'sd16775851;
            7:       return 36'sd8388437;
            8:       return 36'sd4194283;
            9:       return 36'sd2097149;
            default:
            begin
                if (i <= 30)
                    return one << (30 - i);
                else
                    return '0;
            end
        endcase
    endfunction

endpackage

// ----- rtl/c2p_sqrt.sv -----
module c2p_sqrt
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_vld,
    input  logic [c2p_pkg::SQ_W-1:0]         in_rad,
    input  logic signed [c2p_pkg::DOT_W-1:0] in_side,
    output logic                             out_vld,
    output logic [c2p_pkg::ROOT_W-1:0]       out_root,
    output logic signed [c2p_pkg::DOT_W-1:0] out_side
);

    localparam int N  = c2p_pkg::ROOT_W;
    localparam int RW = N + 2;

    logic                             vld_reg  [0:N-1];
    logic [RW-1:0]                    rem_reg  [0:N-1];
    logic [N-1:0]                     root_reg [0:N-1];
    logic [c2p_pkg::SQ_W-1:0]         rad_reg  [0:N-1];
    logic signed [c2p_pkg::DOT_W-1:0] side_reg [0:N-1];

    // One root bit per stage, two radicand bits taken in each.
    for (genvar g = 0; g < N; g++) begin : g_st
        logic                             vld_in;
        logic [RW-1:0]                    rem_in;
        logic [N-1:0]                     root_in;
        logic [c2p_pkg::SQ_W-1:0]         rad_in;
        logic signed [c2p_pkg::DOT_W-1:0] side_in;
        logic [RW+1:0]                    acc;
        logic [RW+1:0]                    trial;
        logic [RW+1:0]                    diff;

        if (g == 0) begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
        end
        else begin : g_next
            assign vld_in  = vld_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rad_in  = rad_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        always_comb
        begin
            acc   = {rem_in, rad_in[c2p_pkg::SQ_W-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            diff  = acc - trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else
                vld_reg[g] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (vld_in)
            begin
                if (acc >= trial)
                begin
                    rem_reg[g]  <= diff[RW-1:0];
                    root_reg[g] <= {root_in[N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g]  <= acc[RW-1:0];
                    root_reg[g] <= {root_in[N-2:0], 1'b0};
                end
                rad_reg[g]  <= rad_in << 2;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_root = root_reg[N-1];
    assign out_side = side_reg[N-1];

endmodule

// ----- rtl/c2p_div.sv -----
module c2p_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic [c2p_pkg::ROOT_W-1:0]    in_rem,
    input  logic [c2p_pkg::ROOT_W-1:0]    in_lo,
    input  logic [c2p_pkg::ROOT_W-1:0]    in_den,
    input  c2p_pkg::rate_flags_t          in_flags,
    output logic                          out_vld,
    output logic [c2p_pkg::ROOT_W-1:0]    out_quo,
    output logic [c2p_pkg::ROOT_W-1:0]    out_den,
    output c2p_pkg::rate_flags_t          out_flags
);

    localparam int N = c2p_pkg::ROOT_W;

    logic                 vld_reg  [0:N-1];
    logic [N-1:0]         rem_reg  [0:N-1];
    logic [N-1:0]         lo_reg   [0:N-1];
    logic [N-1:0]         quo_reg  [0:N-1];
    logic [N-1:0]         den_reg  [0:N-1];
    c2p_pkg::rate_flags_t flg_reg  [0:N-1];

    // Restoring division, one quotient bit per stage.
    for (genvar g = 0; g < N; g++) begin : g_st
        logic                 vld_in;
        logic [N-1:0]         rem_in;
        logic [N-1:0]         lo_in;
        logic [N-1:0]         quo_in;
        logic [N-1:0]         den_in;
        c2p_pkg::rate_flags_t flg_in;
        logic [N:0]           acc;
        logic [N:0]           diff;

        if (g == 0) begin : g_first
            assign vld_in = in_vld;
            assign rem_in = in_rem;
            assign lo_in  = in_lo;
            assign quo_in = '0;
            assign den_in = in_den;
            assign flg_in = in_flags;
        end
        else begin : g_next
            assign vld_in = vld_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign lo_in  = lo_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign den_in = den_reg[g-1];
            assign flg_in = flg_reg[g-1];
        end

        always_comb
        begin
            acc  = {rem_in, lo_in[N-1]};
            diff = acc - {1'b0, den_in};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else
                vld_reg[g] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (vld_in)
            begin
                if (acc >= {1'b0, den_in})
                begin
                    rem_reg[g] <= diff[N-1:0];
                    quo_reg[g] <= {quo_in[N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g] <= acc[N-1:0];
                    quo_reg[g] <= {quo_in[N-2:0], 1'b0};
                end
                lo_reg[g]  <= lo_in << 1;
                den_reg[g] <= den_in;
                flg_reg[g] <= flg_in;
            end
        end
    end

    assign out_vld   = vld_reg[N-1];
    assign out_quo   = quo_reg[N-1];
    assign out_den   = den_reg[N-1];
    assign out_flags = flg_reg[N-1];

endmodule

// ----- rtl/c2p_cordic.sv -----
module c2p_cordic
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_vld,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] in_x,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] in_y,
    output logic                                  out_vld,
    output logic signed [c2p_pkg::BEAR_W-1:0]     out_bearing
);

    localparam int N  = c2p_pkg::CORDIC_STEPS;
    localparam int CW = c2p_pkg::CW;
    localparam int ZW = c2p_pkg::ZW;
    localparam int DW = c2p_pkg::DATA_WIDTH;

    logic                 pre_vld_reg;
    logic                 pre_org_reg;
    logic signed [CW-1:0] pre_x_reg;
    logic signed [CW-1:0] pre_y_reg;
    logic signed [ZW-1:0] pre_z_reg;

    logic                 vld_reg [0:N-1];
    logic                 org_reg [0:N-1];
    logic signed [CW-1:0] x_reg   [0:N-1];
    logic signed [CW-1:0] y_reg   [0:N-1];
    logic signed [ZW-1:0] z_reg   [0:N-1];

    logic                            out_vld_reg;
    logic signed [c2p_pkg::BEAR_W-1:0] bear_reg;

    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;

    // Fold the left half plane onto the right by a turn of pi.
    always_comb
    begin
        xe = {{(CW-DW){in_x[DW-1]}}, in_x};
        ye = {{(CW-DW){in_y[DW-1]}}, in_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_vld_reg <= 1'b0;
        else
            pre_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            pre_org_reg <= (in_x == '0) && (in_y == '0);
            if (in_x[DW-1])
            begin
                pre_x_reg <= -xe;
                pre_y_reg <= -ye;
                pre_z_reg <= in_y[DW-1] ? -c2p_pkg::PI_Q30 : c2p_pkg::PI_Q30;
            end
            else
            begin
                pre_x_reg <= xe;
                pre_y_reg <= ye;
                pre_z_reg <= '0;
            end
        end
    end

    // Vectoring iterations, one per stage.
    for (genvar g = 0; g < N; g++) begin : g_st
        logic                 vld_in;
        logic                 org_in;
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] at;

        if (g == 0) begin : g_first
            assign vld_in = pre_vld_reg;
            assign org_in = pre_org_reg;
            assign x_in   = pre_x_reg;
            assign y_in   = pre_y_reg;
            assign z_in   = pre_z_reg;
        end
        else begin : g_next
            assign vld_in = vld_reg[g-1];
            assign org_in = org_reg[g-1];
            assign x_in   = x_reg[g-1];
            assign y_in   = y_reg[g-1];
            assign z_in   = z_reg[g-1];
        end

        always_comb
        begin
            dx = y_in >>> g;
            dy = x_in >>> g;
            at = c2p_pkg::atan_q30(g);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else
                vld_reg[g] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (vld_in)
            begin
                org_reg[g] <= org_in;
                if (y_in[CW-1])
                begin
                    x_reg[g] <= x_in - dx;
                    y_reg[g] <= y_in + dy;
                    z_reg[g] <= z_in - at;
                end
                else
                begin
                    x_reg[g] <= x_in + dx;
                    y_reg[g] <= y_in - dy;
                    z_reg[g] <= z_in + at;
                end
            end
        end
    end

    // Round to the output format, clamp to plus or minus pi and give zero at the origin.
    logic signed [ZW-1:0] zr;

    always_comb
    begin
        zr = (z_reg[N-1] + c2p_pkg::RND_HALF) >>> c2p_pkg::RND_SH;
        if (zr > c2p_pkg::BEAR_LIM)
            zr = c2p_pkg::BEAR_LIM;
        if (zr < -c2p_pkg::BEAR_LIM)
            zr = -c2p_pkg::BEAR_LIM;
        if (org_reg[N-1])
            zr = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= vld_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[N-1])
            bear_reg <= zr[c2p_pkg::BEAR_W-1:0];
    end

    assign out_vld     = out_vld_reg;
    assign out_bearing = bear_reg;

endmodule

// ----- rtl/cartesian_to_polar_radar.sv -----
// Channel   Signals                                              Direction
// -------   ---------------------------------------------------  ---------------
// command   start, busy, pos_x, pos_y, vel_x, vel_y              in (busy out)
// result    done, range_out, bearing_out, range_rate_out         out
//
// A beat is taken on every cycle with start high; busy is always low.
// After the accepting edge a beat passes two multiply and sum stages, the 32-stage
// square root, one divider setup stage, the 32-stage divider and the output register,
// which raises done. One beat per cycle in total.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so done is a one-cycle strobe per beat.
module cartesian_to_polar_radar
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] pos_x,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] pos_y,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] vel_x,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] vel_y,
    output logic                                  done,
    output logic [c2p_pkg::ROOT_W-1:0]            range_out,
    output logic signed [c2p_pkg::BEAR_W-1:0]     bearing_out,
    output logic signed [c2p_pkg::RATE_W-1:0]     range_rate_out
);

    localparam int SQ_W  = c2p_pkg::SQ_W;
    localparam int DOT_W = c2p_pkg::DOT_W;
    localparam int RW    = c2p_pkg::ROOT_W;
    localparam int RTW   = c2p_pkg::RATE_W;
    localparam int BD    = c2p_pkg::BEAR_DELAY;

    logic                    accept;
    logic                    mul_vld_reg;
    logic signed [SQ_W-1:0]  sqx_reg;
    logic signed [SQ_W-1:0]  sqy_reg;
    logic signed [SQ_W-1:0]  p1_reg;
    logic signed [SQ_W-1:0]  p2_reg;

    logic                    sum_vld_reg;
    logic [SQ_W-1:0]         sum2_reg;
    logic signed [DOT_W-1:0] dot_reg;

    logic                    sq_vld;
    logic [RW-1:0]           sq_root;
    logic signed [DOT_W-1:0] sq_dot;

    logic [DOT_W-1:0]        mag;
    logic                    set_vld_reg;
    logic [RW-1:0]           rem_reg;
    logic [RW-1:0]           lo_reg;
    logic [RW-1:0]           den_reg;
    c2p_pkg::rate_flags_t    flg_reg;

    logic                    dv_vld;
    logic [RW-1:0]           dv_quo;
    logic [RW-1:0]           dv_den;
    c2p_pkg::rate_flags_t    dv_flags;

    logic                    cd_vld;
    logic signed [c2p_pkg::BEAR_W-1:0] cd_bear;
    logic signed [c2p_pkg::BEAR_W-1:0] bear_dly_reg [0:BD-1];

    logic [RTW-1:0]          q_sat;
    logic [RTW-1:0]          rate;

    logic                    done_reg;
    logic [RW-1:0]           range_reg;
    logic signed [c2p_pkg::BEAR_W-1:0] bear_out_reg;
    logic signed [RTW-1:0]   rate_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Squares and velocity products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
            set_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= accept;
            sum_vld_reg <= mul_vld_reg;
            set_vld_reg <= sq_vld;
            done_reg    <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sqx_reg <= pos_x * pos_x;
            sqy_reg <= pos_y * pos_y;
            p1_reg  <= pos_x * vel_x;
            p2_reg  <= pos_y * vel_y;
        end
    end

    // Sum of squares and dot product.
    always_ff @(posedge clk)
    begin
        if (mul_vld_reg)
        begin
            sum2_reg <= $unsigned(sqx_reg) + $unsigned(sqy_reg);
            dot_reg  <= {p1_reg[SQ_W-1], p1_reg} + {p2_reg[SQ_W-1], p2_reg};
        end
    end

    c2p_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (sum_vld_reg),
        .in_rad   (sum2_reg),
        .in_side  (dot_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_dot)
    );

    // Divider setup: magnitude, sign and the overflow test on the upper half.
    assign mag = sq_dot[DOT_W-1] ? (~sq_dot + 1'b1) : sq_dot;

    always_ff @(posedge clk)
    begin
        if (sq_vld)
        begin
            rem_reg       <= mag[SQ_W-1:RW];
            lo_reg        <= mag[RW-1:0];
            den_reg       <= sq_root;
            flg_reg.zero  <= (sq_root == '0);
            flg_reg.sat   <= (mag[SQ_W-1:RW] >= sq_root);
            flg_reg.neg   <= sq_dot[DOT_W-1];
        end
    end

    c2p_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (set_vld_reg),
        .in_rem    (rem_reg),
        .in_lo     (lo_reg),
        .in_den    (den_reg),
        .in_flags  (flg_reg),
        .out_vld   (dv_vld),
        .out_quo   (dv_quo),
        .out_den   (dv_den),
        .out_flags (dv_flags)
    );

    c2p_cordic u_cordic
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (accept),
        .in_x        (pos_x),
        .in_y        (pos_y),
        .out_vld     (cd_vld),
        .out_bearing (cd_bear)
    );

    // Bearing delay line to line up with the divider output.
    always_ff @(posedge clk)
    begin
        bear_dly_reg[0] <= cd_vld ? cd_bear : bear_dly_reg[0];
        for (int i = 1; i < BD; i++)
            bear_dly_reg[i] <= bear_dly_reg[i-1];
    end

    // Saturate, apply the sign and register the result beat.
    always_comb
    begin
        if (dv_flags.zero)
            q_sat = '0;
        else if (dv_flags.sat || ({1'b0, dv_quo} > c2p_pkg::RATE_LIMIT))
            q_sat = c2p_pkg::RATE_LIMIT;
        else
            q_sat = {1'b0, dv_quo};
        rate = dv_flags.neg ? (~q_sat + 1'b1) : q_sat;
    end

    always_ff @(posedge clk)
    begin
        if (dv_vld)
        begin
            range_reg    <= dv_den;
            bear_out_reg <= bear_dly_reg[BD-1];
            rate_reg     <= rate;
        end
    end

    assign done           = done_reg;
    assign range_out      = range_reg;
    assign bearing_out    = bear_out_reg;
    assign range_rate_out = rate_reg;

endmodule

// ----- tb/radar_checker.sv -----
`timescale 1ns / 100ps

// Watches the command and result channels of the radar conversion block,
// computes the expected polar view of each accepted beat and compares.
module radar_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] pos_x,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] pos_y,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] vel_x,
    input  logic signed [c2p_pkg::DATA_WIDTH-1:0] vel_y,
    input  logic                                  done,
    input  logic [c2p_pkg::ROOT_W-1:0]            range_out,
    input  logic signed [c2p_pkg::BEAR_W-1:0]     bearing_out,
    input  logic signed [c2p_pkg::RATE_W-1:0]     range_rate_out,
    output int                                    fail_count,
    output int                                    pending
);
    import c2p_pkg::*;

    typedef struct {
        logic [ROOT_W-1:0]        rng;
        logic signed [BEAR_W-1:0] bear;
        logic signed [RATE_W-1:0] rate;
    } polar_t;

    polar_t polar_q[$];

    // Floor of the exact square root, one result bit at a time.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // Vectoring rotation that turns the position onto the x axis.
    function automatic logic signed [BEAR_W-1:0] calc_bearing(input longint px,
                                                             input longint py);
        longint x, y, z, dx, dy, t, lim, half, step;
        if (px == 0 && py == 0)
            return '0;
        x = px;
        y = py;
        z = 0;
        if (px < 0)
        begin
            x = -px;
            y = -py;
            z = (py >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            step = longint'(atan_table(i));
            if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end
        end
        half = 64'sd1 <<< (30 - FRAC_BITS - 1);
        t = (z + half) >>> (30 - FRAC_BITS);
        lim = (64'sd3373259426 + half) >>> (30 - FRAC_BITS);
        if (t > lim)
            t = lim;
        if (t < -lim)
            t = -lim;
        return t[BEAR_W-1:0];
    endfunction

    // Arctangents of 2^-i in Q30.
    function automatic longint atan_table(input int i);
        case (i)
            0: return 843314857;
            1: return 497837829;
            2: return 263043837;
            3: return 133525159;
            4: return 67021687;
            5: return 33543516;
            6: return 16775851;
            7: return 8388437;
            8: return 4194283;
            9: return 2097149;
            default: return (i <= 30) ? (64'sd1 <<< (30 - i)) : 0;
        endcase
    endfunction

    function automatic polar_t predict_polar(input longint px, input longint py,
                                             input longint vx, input longint vy);
        polar_t p;
        logic [63:0] ax, ay, rho, mag, q;
        logic signed [64:0] dot;
        ax = (px < 0) ? -px : px;
        ay = (py < 0) ? -py : py;
        rho = floor_sqrt(ax * ax + ay * ay);
        dot = 65'(px * vx) + 65'(py * vy);
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        q = (rho != 0) ? mag / rho : 64'd0;
        if (q > 64'd3037000500)
            q = 64'd3037000500;
        p.rng = rho[ROOT_W-1:0];
        p.bear = calc_bearing(px, py);
        p.rate = (dot < 0) ? -$signed({1'b0, q[RATE_W-2:0]}) : q[RATE_W-1:0];
        return p;
    endfunction

    assign pending = polar_q.size();

    // Predict on each accepted command beat; compare on each result beat.
    always @(posedge clk or negedge rst_n)
    begin
        polar_t want;
        int     errs;
        errs = 0;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (polar_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errs = errs + 1;
                end
                else
                begin
                    want = polar_q.pop_front();
                    if (range_out !== want.rng)
                    begin
                        $error("range_out expected %0d actual %0d", want.rng, range_out);
                        errs = errs + 1;
                    end
                    if (bearing_out !== want.bear)
                    begin
                        $error("bearing_out expected %0d actual %0d", want.bear,
                               bearing_out);
                        errs = errs + 1;
                    end
                    if (range_rate_out !== want.rate)
                    begin
                        $error("range_rate_out expected %0d actual %0d", want.rate,
                               range_rate_out);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            if (start && !busy)
                polar_q.push_back(predict_polar(pos_x, pos_y, vel_x, vel_y));
        end
    end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import c2p_pkg::*;

    localparam int RANDOM_BEATS = 1880;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 100;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [DATA_WIDTH-1:0] pos_x, pos_y, vel_x, vel_y;
    logic done;
    logic [ROOT_W-1:0] range_out;
    logic signed [BEAR_W-1:0] bearing_out;
    logic signed [RATE_W-1:0] range_rate_out;
    int fail_count;
    int pending;
    int idle_cycles;

    cartesian_to_polar_radar dut (.*);

    radar_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("cartesian_to_polar_radar verification failed");
            $finish;
        end
    end

    // Send one command beat, with a random gap before it when allow_gap is set.
    task automatic send_state(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] vx, input logic [31:0] vy,
                              input bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 12) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        vel_x <= vx;
        vel_y <= vy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 200000)) - 100000);
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    initial
    begin
        logic [31:0] edge_vals[8];
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF,
                      32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA};
        rst_n = 0;
        start = 0;
        pos_x = 0;
        pos_y = 0;
        vel_x = 0;
        vel_y = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: origin, axes, left half plane on both sides, extremes.
        send_state(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_state(32'hFFFF_0000, 0, 32'h1000, 0, 0);
        send_state(32'hFFFF_0000, 32'hFFFF_FFFF, 5, 7, 0);
        send_state(32'hFFFF_0000, 1, 5, 7, 0);
        send_state(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
        send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_state(1, 0, 32'h7FFF_FFFF, 0, 0);
        send_state(1, 1, 32'h8000_0000, 32'h8000_0000, 0);
        send_state(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0, 0);
        send_state(32'h8000_0000, 0, 0, 0, 0);
        send_state(32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 0);
        for (int i = 0; i < 8; i++)
            send_state(edge_vals[i], edge_vals[7 - i], edge_vals[(i + 3) % 8],
                       edge_vals[(i + 5) % 8], 1);

        // Hold off until the pipeline has drained completely.
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        // Random states, bursts without gaps mixed with idle stretches.
        for (int i = 0; i < RANDOM_BEATS; i++)
            send_state(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       (i / 200) % 2 == 1);
        start <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("cartesian_to_polar_radar verification clean");
        else
            $display("cartesian_to_polar_radar verification failed");
        $finish;
    end
endmodule
